[hdl/etcq_pkg.sv]
package etcq_pkg;

    // Defaults
    localparam int          RING_DEPTH_DEF = 8;
    localparam logic [31:0] MIN_GAP_RESET  = 32'd2000;

    // Opcodes of an input transaction
    localparam logic OP_EDGE = 1'b0;
    localparam logic OP_TAKE = 1'b1;

    // Result status codes
    typedef enum logic [2:0] {
        ST_STORED   = 3'd0,
        ST_TOO_SOON = 3'd1,
        ST_FULL     = 3'd2,
        ST_TAKEN    = 3'd3,
        ST_EMPTY    = 3'd4
    } t_status;

    // Controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_LOAD,
        S_OUT
    } t_state;

    // Input transaction payload
    typedef struct packed {
        logic        opcode;
        logic [31:0] edge_time;
    } t_in_item;

    // Result transaction payload
    typedef struct packed {
        t_status     status;
        logic [31:0] taken_time;
        logic [31:0] accepted_total;
        logic [31:0] rejected_total;
    } t_out_item;

    // Controller to datapath
    typedef struct packed {
        logic    capture;   // latch the input transaction
        logic    update;    // apply the outcome to queue state
        t_status outcome;
        logic    load_out;  // build the result register
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic is_take;
        logic too_soon;
        logic full;
        logic empty;
    } t_dp_flags;

endpackage

[hdl/etcq_ctrl.sv]
module etcq_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    input  etcq_pkg::t_dp_flags i_flags,
    output etcq_pkg::t_dp_cmd   o_cmd
);

    etcq_pkg::t_state r_state;
    etcq_pkg::t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= etcq_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state          = r_state;
        o_in_ready       = 1'b0;
        o_out_valid      = 1'b0;
        o_cmd.capture    = 1'b0;
        o_cmd.update     = 1'b0;
        o_cmd.load_out   = 1'b0;
        o_cmd.outcome    = etcq_pkg::ST_EMPTY;

        // outcome of the held transaction
        if (i_flags.is_take) begin
            o_cmd.outcome = i_flags.empty ? etcq_pkg::ST_EMPTY : etcq_pkg::ST_TAKEN;
        end else if (i_flags.too_soon) begin
            o_cmd.outcome = etcq_pkg::ST_TOO_SOON;
        end else if (i_flags.full) begin
            o_cmd.outcome = etcq_pkg::ST_FULL;
        end else begin
            o_cmd.outcome = etcq_pkg::ST_STORED;
        end

        unique case (r_state)
            etcq_pkg::S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.capture = i_in_valid;
                if (i_in_valid) begin
                    n_state = etcq_pkg::S_EVAL;
                end
            end
            etcq_pkg::S_EVAL: begin
                o_cmd.update = 1'b1;
                n_state      = etcq_pkg::S_LOAD;
            end
            etcq_pkg::S_LOAD: begin
                o_cmd.load_out = 1'b1;
                n_state        = etcq_pkg::S_OUT;
            end
            etcq_pkg::S_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    n_state = etcq_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = etcq_pkg::S_IDLE;
            end
        endcase
    end

endmodule

[hdl/etcq_datapath.sv]
module etcq_datapath #(
    parameter int RING_DEPTH = etcq_pkg::RING_DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [31:0]         i_cfg_wdata,
    input  etcq_pkg::t_in_item  i_in_data,
    input  etcq_pkg::t_dp_cmd   i_cmd,
    output etcq_pkg::t_dp_flags o_flags,
    output etcq_pkg::t_out_item o_out_data
);

    localparam int SLOT_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(RING_DEPTH - 1);

    logic [31:0]         r_time_store [RING_DEPTH];
    logic [31:0]         r_rd_data;
    etcq_pkg::t_in_item  r_in;
    logic [SLOT_W-1:0]   r_wr_slot;
    logic [SLOT_W-1:0]   r_rd_slot;
    logic [31:0]         r_last_kept;
    logic [31:0]         r_acc_cnt;
    logic [31:0]         r_rej_cnt;
    logic [31:0]         r_min_gap;
    etcq_pkg::t_status   r_status;
    etcq_pkg::t_out_item r_out;

    logic [SLOT_W-1:0]   wr_next;
    logic [SLOT_W-1:0]   rd_next;
    logic [31:0]         gap;

    // Ring pointer increments, wrapping at the depth
    assign wr_next = (r_wr_slot == LAST_SLOT) ? '0 : r_wr_slot + 1'b1;
    assign rd_next = (r_rd_slot == LAST_SLOT) ? '0 : r_rd_slot + 1'b1;

    // Decision flags for the held transaction
    assign gap              = r_in.edge_time - r_last_kept;
    assign o_flags.is_take  = (r_in.opcode == etcq_pkg::OP_TAKE);
    assign o_flags.too_soon = (r_last_kept != '0) && (gap < r_min_gap);
    assign o_flags.full     = (wr_next == r_rd_slot);
    assign o_flags.empty    = (r_rd_slot == r_wr_slot);

    // Gap register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_gap <= etcq_pkg::MIN_GAP_RESET;
        end else if (i_cfg_we) begin
            r_min_gap <= i_cfg_wdata;
        end
    end

    // Input capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_in <= i_in_data;
        end
    end

    // Timestamp memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.update && i_cmd.outcome == etcq_pkg::ST_STORED) begin
            r_time_store[r_wr_slot] <= r_in.edge_time;
        end
        r_rd_data <= r_time_store[r_rd_slot];
    end

    // Queue state and totals
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_slot   <= '0;
            r_rd_slot   <= '0;
            r_last_kept <= '0;
            r_acc_cnt   <= '0;
            r_rej_cnt   <= '0;
        end else if (i_cmd.update) begin
            case (i_cmd.outcome)
                etcq_pkg::ST_STORED: begin
                    r_last_kept <= r_in.edge_time;
                    r_wr_slot   <= wr_next;
                    r_acc_cnt   <= r_acc_cnt + 32'd1;
                end
                etcq_pkg::ST_FULL: begin
                    // last kept time moves even though the edge is dropped
                    r_last_kept <= r_in.edge_time;
                    r_rej_cnt   <= r_rej_cnt + 32'd1;
                end
                etcq_pkg::ST_TOO_SOON: begin
                    r_rej_cnt <= r_rej_cnt + 32'd1;
                end
                etcq_pkg::ST_TAKEN: begin
                    r_rd_slot <= rd_next;
                end
                default: begin
                end
            endcase
        end
    end

    // Outcome held for the result stage
    always_ff @(posedge i_clk) begin
        if (i_cmd.update) begin
            r_status <= i_cmd.outcome;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out.status         <= r_status;
            r_out.taken_time     <= (r_status == etcq_pkg::ST_TAKEN) ? r_rd_data : '0;
            r_out.accepted_total <= r_acc_cnt;
            r_out.rejected_total <= r_rej_cnt;
        end
    end

    assign o_out_data = r_out;

    // A store never lands in a full ring
    a_store_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.update && i_cmd.outcome == etcq_pkg::ST_STORED) |-> !o_flags.full)
        else $error("store issued while ring full");

    // A pop never comes from an empty ring
    a_take_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.update && i_cmd.outcome == etcq_pkg::ST_TAKEN) |-> !o_flags.empty)
        else $error("pop issued while ring empty");

    // Read slot moves only on a pop
    a_rd_slot_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.update && i_cmd.outcome == etcq_pkg::ST_TAKEN) |=> $stable(r_rd_slot))
        else $error("read slot moved without a pop");

    // A store always advances the write slot
    a_wr_slot_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.update && i_cmd.outcome == etcq_pkg::ST_STORED)
        |=> (r_wr_slot != $past(r_wr_slot)))
        else $error("write slot did not advance on store");

endmodule

[hdl/edge_timestamp_capture_queue_top.sv]
// Edge timestamp capture queue. Each input transaction is either a falling-edge
// report carrying the microsecond timer value, or a request to take the oldest
// stored timestamp; each one yields exactly one result transaction with a
// status, the popped time (zero unless taken) and the running stored and
// rejected totals. An edge is dropped as too soon when one has already been
// kept (last kept time nonzero) and the wrapped difference is below min_gap_us;
// otherwise it becomes the last kept time and is stored unless the ring, which
// holds RING_DEPTH-1 entries, is full. The block handles one transaction at a
// time: accept, evaluate, load the result, deliver, with the result held in
// the last step until the sink takes it; this sequence is set by the
// controller around the registered read of the timestamp memory. No clearing
// pass follows reset. The user must write min_gap_us through i_cfg_we and
// i_cfg_wdata only while the block is idle; the block does not enforce it.
module edge_timestamp_capture_queue_top #(
    parameter int RING_DEPTH = etcq_pkg::RING_DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [31:0]         i_cfg_wdata,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  etcq_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output etcq_pkg::t_out_item o_out_data
);

    etcq_pkg::t_dp_cmd   cmd;
    etcq_pkg::t_dp_flags flags;

    // Sequencer
    etcq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_flags     (flags),
        .o_cmd       (cmd)
    );

    // Ring, counters and result register
    etcq_datapath #(
        .RING_DEPTH (RING_DEPTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_flags     (flags),
        .o_out_data  (o_out_data)
    );

endmodule

[tb/edge_timestamp_capture_queue_top_test.sv]
module edge_timestamp_capture_queue_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RING_SLOTS  = etcq_pkg::RING_DEPTH_DEF;
    localparam int STALL_LIMIT = 2000;
    localparam int PHASE_ITEMS = 400;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                cfg_we = 1'b0;
    logic [31:0]         cfg_wdata = '0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    etcq_pkg::t_in_item  in_data = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    etcq_pkg::t_out_item out_data;

    edge_timestamp_capture_queue_top u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_wdata(cfg_wdata),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_data (out_data)
    );

    // Pending edge/take transactions and the results they should produce
    etcq_pkg::t_in_item  pending_items[$];
    etcq_pkg::t_out_item expected_results[$];

    int unsigned mismatches = 0;
    int unsigned sender_idle_pct = 0;
    int unsigned sink_stall_pct = 0;
    int unsigned quiet_cycles = 0;

    // Shadow of the capture queue
    logic [31:0] gap_us = etcq_pkg::MIN_GAP_RESET;
    logic [31:0] ring_times[RING_SLOTS];
    int unsigned wr_slot = 0;
    int unsigned rd_slot = 0;
    logic [31:0] last_kept = '0;
    logic [31:0] n_stored = '0;
    logic [31:0] n_rejected = '0;

    // Generator state: timer value seen by the edge source, moved per generated edge
    logic [31:0] timer_us = '0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string what);
        $display("[%0t] MISMATCH: %s", $realtime, what);
        mismatches++;
    endtask

    // Apply one transaction to the shadow queue and return its result
    function automatic etcq_pkg::t_out_item predict_capture(input etcq_pkg::t_in_item item);
        etcq_pkg::t_out_item res;
        int unsigned         nxt;
        res = '0;
        if (item.opcode == etcq_pkg::OP_EDGE) begin
            if (last_kept != 0 && (item.edge_time - last_kept) < gap_us) begin
                n_rejected++;
                res.status = etcq_pkg::ST_TOO_SOON;
            end else begin
                // last kept time moves even if the ring then turns out full
                last_kept = item.edge_time;
                nxt = (wr_slot + 1) % RING_SLOTS;
                if (nxt == rd_slot) begin
                    n_rejected++;
                    res.status = etcq_pkg::ST_FULL;
                end else begin
                    ring_times[wr_slot] = item.edge_time;
                    wr_slot = nxt;
                    n_stored++;
                    res.status = etcq_pkg::ST_STORED;
                end
            end
        end else begin
            if (rd_slot == wr_slot) begin
                res.status = etcq_pkg::ST_EMPTY;
            end else begin
                res.taken_time = ring_times[rd_slot];
                rd_slot = (rd_slot + 1) % RING_SLOTS;
                res.status = etcq_pkg::ST_TAKEN;
            end
        end
        res.accepted_total = n_stored;
        res.rejected_total = n_rejected;
        return res;
    endfunction

    function automatic etcq_pkg::t_in_item make_item(input logic op, input logic [31:0] t);
        etcq_pkg::t_in_item item;
        item.opcode = op;
        item.edge_time = t;
        return item;
    endfunction

    // Timer advance mostly near the gap so both outcomes of the check occur
    function automatic logic [31:0] next_edge_time();
        case ($urandom_range(0, 9))
            0, 1, 2: timer_us += (gap_us == 0) ? 32'd0 : $urandom % gap_us;
            3, 4:    timer_us += gap_us - 32'd1 + $urandom_range(0, 2);
            5, 6, 7: timer_us += gap_us + $urandom_range(0, 1000);
            8:       timer_us = $urandom;
            default: timer_us = '0;
        endcase
        return timer_us;
    endfunction

    // Bursts biased towards edges or takes so the ring fills and drains
    task automatic queue_random(input int n);
        int unsigned edge_pct;
        edge_pct = 50;
        for (int i = 0; i < n; i++) begin
            if (i % 16 == 0) edge_pct = $urandom_range(0, 2) * 25 + 30;
            if ($urandom_range(0, 99) < edge_pct)
                pending_items.push_back(make_item(etcq_pkg::OP_EDGE, next_edge_time()));
            else
                pending_items.push_back(make_item(etcq_pkg::OP_TAKE, $urandom));
        end
    endtask

    task automatic wait_idle();
        while (pending_items.size() != 0 || in_valid || expected_results.size() != 0)
            @(negedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic write_gap(input logic [31:0] value);
        @(posedge i_clk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        gap_us = value;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    // Stimulus sequencing
    initial begin
        logic [31:0] phase_gap[5];
        int unsigned idle_pct[5];
        int unsigned stall_pct[5];
        phase_gap = '{etcq_pkg::MIN_GAP_RESET, 32'd0, 32'hFFFF_FFFF, 32'd1, 32'd1};
        phase_gap[3] = $urandom_range(1, 64);
        phase_gap[4] = $urandom_range(1000, 100000);
        idle_pct  = '{0, 78, 0, 24, 0};
        stall_pct = '{0, 0, 78, 24, 0};

        for (int i = 0; i < RING_SLOTS; i++) ring_times[i] = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: reset gap, empty pop, edge at zero, wrap, exact gap,
        // full ring with last kept time moving, drain past empty
        pending_items.push_back(make_item(etcq_pkg::OP_TAKE, 32'hFFFF_FFFF));
        pending_items.push_back(make_item(etcq_pkg::OP_EDGE, 32'd0));
        pending_items.push_back(make_item(etcq_pkg::OP_EDGE, 32'd5));
        pending_items.push_back(make_item(etcq_pkg::OP_EDGE, 32'd100));
        pending_items.push_back(make_item(etcq_pkg::OP_EDGE, 32'hFFFF_FFFF));
        pending_items.push_back(make_item(etcq_pkg::OP_EDGE, 32'd1998));
        pending_items.push_back(make_item(etcq_pkg::OP_EDGE, 32'd1999));
        pending_items.push_back(make_item(etcq_pkg::OP_EDGE, 32'd4000));
        pending_items.push_back(make_item(etcq_pkg::OP_EDGE, 32'd6000));
        pending_items.push_back(make_item(etcq_pkg::OP_EDGE, 32'd8000));
        pending_items.push_back(make_item(etcq_pkg::OP_EDGE, 32'd10000));
        pending_items.push_back(make_item(etcq_pkg::OP_EDGE, 32'd11000));
        pending_items.push_back(make_item(etcq_pkg::OP_EDGE, 32'd12000));
        for (int i = 0; i < RING_SLOTS; i++)
            pending_items.push_back(make_item(etcq_pkg::OP_TAKE, 32'h0));
        pending_items.push_back(make_item(etcq_pkg::OP_EDGE, 32'h8000_0000));
        pending_items.push_back(make_item(etcq_pkg::OP_TAKE, 32'h5555_5555));
        pending_items.push_back(make_item(etcq_pkg::OP_TAKE, 32'hAAAA_AAAA));
        wait_idle();

        for (int p = 0; p < 5; p++) begin
            if (p != 0) begin
                wait_idle();
                write_gap(phase_gap[p]);
            end
            sender_idle_pct = idle_pct[p];
            sink_stall_pct = stall_pct[p];
            timer_us = $urandom;
            queue_random(PHASE_ITEMS);
        end

        wait_idle();
        repeat (10) @(posedge i_clk);
        if (expected_results.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_results.size()));
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Driver: predicts on acceptance, then offers the next transaction
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && in_ready)
                expected_results.push_back(predict_capture(in_data));
            if (!in_valid || in_ready) begin
                if (pending_items.size() != 0 &&
                    $urandom_range(0, 99) >= sender_idle_pct) begin
                    in_valid <= 1'b1;
                    in_data <= pending_items.pop_front();
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: result transactions against the oldest expectation
    always @(posedge i_clk) begin
        etcq_pkg::t_out_item want;
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("unexpected result %h", out_data));
                end else begin
                    want = expected_results.pop_front();
                    if (out_data.status !== want.status)
                        report_mismatch($sformatf("status got %0d want %0d",
                                                  out_data.status, want.status));
                    if (out_data.taken_time !== want.taken_time)
                        report_mismatch($sformatf("taken_time got %h want %h",
                                                  out_data.taken_time, want.taken_time));
                    if (out_data.accepted_total !== want.accepted_total)
                        report_mismatch($sformatf("accepted_total got %h want %h",
                                                  out_data.accepted_total,
                                                  want.accepted_total));
                    if (out_data.rejected_total !== want.rejected_total)
                        report_mismatch($sformatf("rejected_total got %h want %h",
                                                  out_data.rejected_total,
                                                  want.rejected_total));
                end
            end
            out_ready <= ($urandom_range(0, 99) >= sink_stall_pct);
        end
    end

    // Watchdog: too long without any transaction on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("[%0t] watchdog expired", $realtime);
            $display("Some tests failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule

[filelist.f]
hdl/etcq_pkg.sv
hdl/etcq_ctrl.sv
hdl/etcq_datapath.sv
hdl/edge_timestamp_capture_queue_top.sv
tb/edge_timestamp_capture_queue_top_test.sv
